FILE: hdl/gbn_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the Go-Back-N sender.
// Used by the result channel interface and by the top level go_back_n_sender.
package gbn_pkg;

  localparam int unsigned SEQ_W   = 31;
  localparam int unsigned PAY_W   = 160;
  localparam int unsigned BSUM_W  = 13;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned BYTES_PER_STEP = 4;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] KIND_NEW     = 3'd0;
  localparam logic [2:0] KIND_RESENT  = 3'd1;
  localparam logic [2:0] KIND_QUEUED  = 3'd2;
  localparam logic [2:0] KIND_DROPPED = 3'd3;
  localparam logic [2:0] KIND_ACKED   = 3'd4;
  localparam logic [2:0] KIND_CORRUPT = 3'd5;
  localparam logic [2:0] KIND_RANGE   = 3'd6;
  localparam logic [2:0] KIND_IDLE    = 3'd7;

  localparam logic [CIDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_WINDOW  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BUFFER  = 2'd2;

  typedef struct packed {
    logic [PAY_W-1:0]         pay;
    logic signed [BSUM_W-1:0] bsum;
  } entry_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [SEQ_W-1:0] seq;
    logic [31:0]      cksum;
    logic [PAY_W-1:0] pay;
    logic             last;
  } result_t;

endpackage

FILE: hdl/gbn_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sender's command and result items.
// Depends on gbn_pkg for field widths.
interface gbn_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [63:0]         payload_low;
  logic [63:0]         payload_mid;
  logic [31:0]         payload_high;
  logic signed [31:0]  in_seqnum;
  logic signed [31:0]  in_acknum;
  logic signed [31:0]  in_checksum;
  modport source (output valid, cmd, payload_low, payload_mid, payload_high,
                  in_seqnum, in_acknum, in_checksum, input ready);
  modport sink   (input valid, cmd, payload_low, payload_mid, payload_high,
                  in_seqnum, in_acknum, in_checksum, output ready);
endinterface

interface gbn_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    kind;
  logic [gbn_pkg::SEQ_W-1:0]     out_seqnum;
  logic                          out_acknum;
  logic signed [31:0]            out_checksum;
  logic [63:0]                   out_payload_low;
  logic [63:0]                   out_payload_mid;
  logic [31:0]                   out_payload_high;
  logic                          last;
  modport source (output valid, kind, out_seqnum, out_acknum, out_checksum,
                  out_payload_low, out_payload_mid, out_payload_high, last,
                  input ready);
  modport sink   (input valid, kind, out_seqnum, out_acknum, out_checksum,
                  out_payload_low, out_payload_mid, out_payload_high, last,
                  output ready);
endinterface

FILE: hdl/go_back_n_sender.sv
`timescale 1ns / 1ps
// Go-Back-N sender: window store, overflow queue, timer and result sequencer.
// Depends on gbn_pkg and the channel interfaces in gbn_if.sv.
//
//  channel  | dir | handshake       | carries
//  in_if    | in  | valid / ready   | command, 20 payload bytes, ack fields
//  out_if   | out | valid / ready   | kind, packet fields, last
//  cfg_*    | in  | cfg_we          | register index and write data
//
// An item is accepted in the idle state, then takes the byte sum (four bytes per step)
// and a decision state; a single result is then sent from the emit state. A resent
// packet takes a registered read and a send state; a packet drained from the queue
// takes a check, a registered read and a send state, plus a final check.
// Reset (rst_n low, synchronous) empties the window and queue; no clearing pass.
// The block takes one item at a time; a stalled result holds the sequencer.
module go_back_n_sender #(
  parameter int unsigned MAX_WINDOW    = 8,
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned PAYLOAD_BYTES = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gbn_in_if.sink                            in_if,
  gbn_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [gbn_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int unsigned SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned OW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_STEPS = (PAYLOAD_BYTES + gbn_pkg::BYTES_PER_STEP - 1) /
                                      gbn_pkg::BYTES_PER_STEP;
  localparam int unsigned STW = $clog2(SUM_STEPS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SUM   = 10'b0000000010,
    S_DEC   = 10'b0000000100,
    S_DCHK  = 10'b0000001000,
    S_DRD   = 10'b0000010000,
    S_DSEND = 10'b0000100000,
    S_RRD   = 10'b0001000000,
    S_RSEND = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] tmo_r;
  logic [3:0]  wlim_r;
  logic [6:0]  blim_r;

  // Captured item.
  logic [1:0]                    cmd_r;
  logic [gbn_pkg::PAY_W-1:0]     pay_r, shift_r, shift_nxt;
  logic [31:0]                   sq_r, ack_r, ck_r;
  logic signed [gbn_pkg::BSUM_W-1:0] sum_r, sum_nxt;
  logic [STW-1:0]                step_r, step_nxt;

  // Protocol state.
  logic [gbn_pkg::SEQ_W-1:0] base_r, base_nxt, nseq_r, nseq_nxt;
  logic [SW-1:0]             head_r, head_nxt;
  logic [QW-1:0]             qhead_r, qhead_nxt, qtail_r, qtail_nxt;
  logic [CW-1:0]             qcnt_r, qcnt_nxt;
  logic                      trun_r, trun_nxt;
  logic [15:0]               trem_r, trem_nxt;
  logic [OW-1:0]             cnt_r, cnt_nxt, idx_r, idx_nxt;
  gbn_pkg::result_t          res_r, res_nxt, out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Memories.
  gbn_pkg::entry_t w_mem [MAX_WINDOW];
  gbn_pkg::entry_t q_mem [QUEUE_DEPTH];
  gbn_pkg::entry_t w_rd_r, q_rd_r, w_wdata;
  logic            w_we, q_we;
  logic [SW-1:0]   w_waddr, w_raddr;

  // Derived values.
  logic [OW-1:0]   outs, effw;
  logic [CW-1:0]   effb;
  logic [15:0]     efft;
  logic            room, qfull, ck_ok, ack_bad, more, out_free, emit;
  logic [30:0]     ack_off;
  logic [SW-1:0]   wslot_new;
  logic [OW-1:0]   ack_n;
  gbn_pkg::entry_t in_entry;

  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a,
                                            input logic [OW-1:0] b);
    logic [31:0] t;
    t = 32'(a) + 32'(b);
    if (t >= MAX_WINDOW) t = t - MAX_WINDOW;
    return SW'(t);
  endfunction

  function automatic logic [31:0] pk_sum(input logic signed [gbn_pkg::BSUM_W-1:0] s,
                                         input logic [gbn_pkg::SEQ_W-1:0] q);
    return 32'(s) + {1'b0, q};
  endfunction

  function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : QW'(32'(p) + 1);
  endfunction

  always_comb begin
    outs = OW'(31'(nseq_r - base_r));
    if (wlim_r == 4'd0) effw = OW'(1);
    else if (32'(wlim_r) > MAX_WINDOW) effw = OW'(MAX_WINDOW);
    else effw = OW'(wlim_r);
    if (blim_r == 7'd0) effb = CW'(1);
    else if (32'(blim_r) > QUEUE_DEPTH) effb = CW'(QUEUE_DEPTH);
    else effb = CW'(blim_r);
    efft      = (tmo_r == 16'd0) ? 16'd1 : tmo_r;
    room      = outs < effw;
    qfull     = 32'(qcnt_r) >= 32'(effb);
    ck_ok     = (32'(sum_r) + sq_r + ack_r) == ck_r;
    ack_off   = ack_r[30:0] - base_r;
    ack_bad   = ack_r[31] || (ack_off >= 31'(outs));
    ack_n     = OW'(ack_off) + OW'(1);
    wslot_new = slot_add(head_r, outs);
    w_raddr   = slot_add(head_r, idx_r);
    more      = (32'(qcnt_r) > 1) && (32'(outs) + 1 < 32'(effw)) &&
                (32'(cnt_r) + 1 < MAX_WINDOW);
    out_free  = !out_valid_r || out_if.ready;
    in_entry.pay  = pay_r;
    in_entry.bsum = sum_r;
  end

  // Byte sum step: four signed bytes per cycle, bytes past the payload length masked.
  always_comb begin
    logic signed [gbn_pkg::BSUM_W-1:0] acc;
    acc = sum_r;
    for (int j = 0; j < gbn_pkg::BYTES_PER_STEP; j++) begin
      if (32'(step_r) * gbn_pkg::BYTES_PER_STEP + j < PAYLOAD_BYTES)
        acc = acc + gbn_pkg::BSUM_W'($signed(shift_r[8*j +: 8]));
    end
    sum_nxt = acc;
  end

  always_comb begin
    state_nxt = state_r;
    shift_nxt = shift_r;
    step_nxt  = step_r;
    base_nxt  = base_r;
    nseq_nxt  = nseq_r;
    head_nxt  = head_r;
    qhead_nxt = qhead_r;
    qtail_nxt = qtail_r;
    qcnt_nxt  = qcnt_r;
    trun_nxt  = trun_r;
    trem_nxt  = trem_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;
    emit      = 1'b0;
    out_nxt   = out_r;
    w_we      = 1'b0;
    w_waddr   = wslot_new;
    w_wdata   = in_entry;
    q_we      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          state_nxt = S_SUM;
          shift_nxt = {in_if.payload_high, in_if.payload_mid, in_if.payload_low};
          step_nxt  = '0;
        end
      end
      S_SUM: begin
        shift_nxt = shift_r >> 32;
        step_nxt  = step_r + STW'(1);
        if (32'(step_r) == SUM_STEPS - 1) state_nxt = S_DEC;
      end
      S_DEC: begin
        res_nxt      = '0;
        res_nxt.last = 1'b1;
        state_nxt    = S_EMIT;
        unique case (cmd_r)
          gbn_pkg::CMD_SEND: begin
            if (room) begin
              w_we          = 1'b1;
              res_nxt.kind  = gbn_pkg::KIND_NEW;
              res_nxt.seq   = nseq_r;
              res_nxt.cksum = pk_sum(sum_r, nseq_r);
              res_nxt.pay   = pay_r;
              nseq_nxt      = nseq_r + 31'd1;
              if (!trun_r) begin
                trun_nxt = 1'b1;
                trem_nxt = efft;
              end
            end else if (qfull) begin
              res_nxt.kind = gbn_pkg::KIND_DROPPED;
            end else begin
              q_we         = 1'b1;
              qtail_nxt    = q_inc(qtail_r);
              qcnt_nxt     = qcnt_r + CW'(1);
              res_nxt.kind = gbn_pkg::KIND_QUEUED;
            end
          end
          gbn_pkg::CMD_ACK: begin
            if (!ck_ok) begin
              res_nxt.kind = gbn_pkg::KIND_CORRUPT;
            end else if (ack_bad) begin
              res_nxt.kind = gbn_pkg::KIND_RANGE;
            end else begin
              base_nxt = ack_r[30:0] + 31'd1;
              head_nxt = slot_add(head_r, ack_n);
              if (ack_n < outs) begin
                trun_nxt = 1'b1;
                trem_nxt = efft;
              end else begin
                trun_nxt = 1'b0;
                trem_nxt = '0;
              end
              cnt_nxt   = '0;
              state_nxt = S_DCHK;
            end
          end
          gbn_pkg::CMD_TICK: begin
            res_nxt.kind = gbn_pkg::KIND_IDLE;
            if (trun_r && trem_r > 16'd1) begin
              trem_nxt = trem_r - 16'd1;
            end else if (trun_r && outs == '0) begin
              trun_nxt = 1'b0;
              trem_nxt = '0;
            end else if (trun_r) begin
              trem_nxt  = efft;
              idx_nxt   = '0;
              state_nxt = S_RRD;
            end
          end
          default: res_nxt.kind = gbn_pkg::KIND_IDLE;
        endcase
      end
      S_DCHK: begin
        if (qcnt_r != '0 && room && 32'(cnt_r) < MAX_WINDOW) begin
          state_nxt = S_DRD;
        end else if (cnt_r == '0) begin
          res_nxt      = '0;
          res_nxt.kind = gbn_pkg::KIND_ACKED;
          res_nxt.last = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DRD: state_nxt = S_DSEND;
      S_DSEND: begin
        if (out_free) begin
          emit          = 1'b1;
          out_nxt.kind  = gbn_pkg::KIND_NEW;
          out_nxt.seq   = nseq_r;
          out_nxt.cksum = pk_sum(q_rd_r.bsum, nseq_r);
          out_nxt.pay   = q_rd_r.pay;
          out_nxt.last  = !more;
          w_we          = 1'b1;
          w_wdata       = q_rd_r;
          nseq_nxt      = nseq_r + 31'd1;
          if (!trun_r) begin
            trun_nxt = 1'b1;
            trem_nxt = efft;
          end
          qhead_nxt = q_inc(qhead_r);
          qcnt_nxt  = qcnt_r - CW'(1);
          cnt_nxt   = cnt_r + OW'(1);
          state_nxt = S_DCHK;
        end
      end
      S_RRD: state_nxt = S_RSEND;
      S_RSEND: begin
        if (out_free) begin
          emit          = 1'b1;
          out_nxt.kind  = gbn_pkg::KIND_RESENT;
          out_nxt.seq   = base_r + 31'(idx_r);
          out_nxt.cksum = pk_sum(w_rd_r.bsum, base_r + 31'(idx_r));
          out_nxt.pay   = w_rd_r.pay;
          out_nxt.last  = (idx_r + OW'(1)) == outs;
          idx_nxt       = idx_r + OW'(1);
          state_nxt     = ((idx_r + OW'(1)) == outs) ? S_IDLE : S_RRD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    if (emit) out_valid_nxt = 1'b1;
    else if (out_if.ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tmo_r       <= 16'd20;
      wlim_r      <= 4'd8;
      blim_r      <= 7'd50;
      base_r      <= 31'd1;
      nseq_r      <= 31'd1;
      head_r      <= '0;
      qhead_r     <= '0;
      qtail_r     <= '0;
      qcnt_r      <= '0;
      trun_r      <= 1'b0;
      trem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      nseq_r      <= nseq_nxt;
      head_r      <= head_nxt;
      qhead_r     <= qhead_nxt;
      qtail_r     <= qtail_nxt;
      qcnt_r      <= qcnt_nxt;
      trun_r      <= trun_nxt;
      trem_r      <= trem_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          gbn_pkg::CFG_TIMEOUT: tmo_r  <= cfg_wdata;
          gbn_pkg::CFG_WINDOW:  wlim_r <= cfg_wdata[3:0];
          gbn_pkg::CFG_BUFFER:  blim_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // Payload and sequencer working registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_if.valid) begin
      cmd_r <= in_if.cmd;
      pay_r <= {in_if.payload_high, in_if.payload_mid, in_if.payload_low};
      sq_r  <= in_if.in_seqnum;
      ack_r <= in_if.in_acknum;
      ck_r  <= in_if.in_checksum;
      sum_r <= '0;
    end else if (state_r == S_SUM) begin
      sum_r <= sum_nxt;
    end
    shift_r <= shift_nxt;
    step_r  <= step_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    w_rd_r <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[qtail_r] <= in_entry;
    q_rd_r <= q_mem[qhead_r];
  end

  assign in_if.ready             = (state_r == S_IDLE);
  assign out_if.valid            = out_valid_r;
  assign out_if.kind             = out_r.kind;
  assign out_if.out_seqnum       = out_r.seq;
  assign out_if.out_acknum       = 1'b0;
  assign out_if.out_checksum     = out_r.cksum;
  assign out_if.out_payload_low  = out_r.pay[63:0];
  assign out_if.out_payload_mid  = out_r.pay[127:64];
  assign out_if.out_payload_high = out_r.pay[159:128];
  assign out_if.last             = out_r.last;

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(outs) <= MAX_WINDOW) else $error("outstanding count exceeds window store");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(qcnt_r) <= QUEUE_DEPTH) else $error("queue count exceeds queue depth");

  a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !trun_r |-> trem_r == 16'd0) else $error("stopped timer holds a count");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind != gbn_pkg::KIND_NEW && out_r.kind != gbn_pkg::KIND_RESENT
    |-> out_r.seq == '0 && out_r.cksum == '0)
    else $error("non-packet result carries packet fields");

endmodule

FILE: verif/gbn_tb_pkg.sv
`timescale 1ns / 1ps
// Result record and packet checksum helper shared by the sender testbench.
// Depends on gbn_pkg for the sequence and payload widths.
package gbn_tb_pkg;
  import gbn_pkg::*;

  typedef struct packed {
    logic [2:0]       kind;
    logic [SEQ_W-1:0] seq;
    logic [31:0]      cksum;
    logic [PAY_W-1:0] pay;
    logic             last;
  } pkt_result_t;

  // Wrapping sum of the twenty payload bytes, each taken as signed.
  function automatic logic [31:0] payload_byte_sum(logic [PAY_W-1:0] pay);
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < 20; i++) begin
      s = s + {{24{pay[8*i+7]}}, pay[8*i +: 8]};
    end
    return s;
  endfunction
endpackage

FILE: verif/gbn_checker.sv
`timescale 1ns / 1ps
// Checker for the Go-Back-N sender: predicts the result items of every
// accepted command item and compares them with the result channel.
// Depends on gbn_pkg, gbn_tb_pkg and the channel interfaces.
module gbn_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  gbn_in_if                         in_ch,
  gbn_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [gbn_pkg::CIDX_W-1:0] cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0]  cfg_wdata,
  output int                        fails,
  output int                        pending,
  output int                        n_items,
  output int                        n_results,
  output logic [gbn_pkg::SEQ_W-1:0] base_o,
  output logic [gbn_pkg::SEQ_W-1:0] next_o
);
  import gbn_pkg::*;
  import gbn_tb_pkg::*;

  logic [15:0]      timeout_reg;
  logic [3:0]       window_reg;
  logic [6:0]       buffer_reg;
  logic [SEQ_W-1:0] win_base;
  logic [SEQ_W-1:0] next_seq;
  logic [PAY_W-1:0] sent_store [8];
  logic [PAY_W-1:0] backlog [$];
  logic             timer_on;
  logic [15:0]      ticks_left;
  pkt_result_t      awaited [$];
  pkt_result_t      step_res [$];

  assign pending = awaited.size();
  assign base_o  = win_base;
  assign next_o  = next_seq;

  function automatic int unsigned eff_window();
    if (window_reg == 0) return 1;
    if (window_reg > 8) return 8;
    return window_reg;
  endfunction

  function automatic int unsigned eff_buffer();
    if (buffer_reg == 0) return 1;
    if (buffer_reg > 64) return 64;
    return buffer_reg;
  endfunction

  function automatic logic [15:0] eff_timeout();
    return (timeout_reg == 0) ? 16'd1 : timeout_reg;
  endfunction

  function automatic logic [SEQ_W-1:0] in_flight();
    return next_seq - win_base;
  endfunction

  function automatic void note(logic [2:0] kind, logic [SEQ_W-1:0] seq,
                               logic [PAY_W-1:0] pay, bit is_pkt);
    pkt_result_t r;
    r = '0;
    r.kind = kind;
    if (is_pkt) begin
      r.seq   = seq;
      r.cksum = payload_byte_sum(pay) + {1'b0, seq};
      r.pay   = pay;
    end
    step_res.push_back(r);
  endfunction

  function automatic void transmit(logic [PAY_W-1:0] pay);
    logic [SEQ_W-1:0] off;
    off = in_flight();
    if (off < 8) sent_store[off] = pay;
    note(KIND_NEW, next_seq, pay, 1);
    next_seq = next_seq + 1'b1;
    if (!timer_on) begin
      timer_on   = 1'b1;
      ticks_left = eff_timeout();
    end
  endfunction

  function automatic void predict(logic [1:0] cmd, logic [PAY_W-1:0] pay,
                                  logic [31:0] sq, logic [31:0] ack, logic [31:0] ck);
    logic [SEQ_W-1:0] outs, off, n, rest;
    step_res.delete();
    outs = in_flight();
    case (cmd)
      CMD_SEND: begin
        if (outs < eff_window()) transmit(pay);
        else if (backlog.size() >= eff_buffer()) note(KIND_DROPPED, 0, 0, 0);
        else begin
          backlog.push_back(pay);
          note(KIND_QUEUED, 0, 0, 0);
        end
      end
      CMD_ACK: begin
        off = ack[SEQ_W-1:0] - win_base;
        if (payload_byte_sum(pay) + sq + ack != ck) note(KIND_CORRUPT, 0, 0, 0);
        else if (ack[31] || off >= outs) note(KIND_RANGE, 0, 0, 0);
        else begin
          n = off + 1'b1;
          rest = outs - n;
          if (rest > 0 && n < 8 && rest <= 8 - n)
            for (int i = 0; i < rest; i++) sent_store[i] = sent_store[i + n];
          win_base = ack[SEQ_W-1:0] + 1'b1;
          timer_on   = (rest > 0);
          ticks_left = (rest > 0) ? eff_timeout() : 16'd0;
          while (backlog.size() > 0 && in_flight() < eff_window() && step_res.size() < 8)
            transmit(backlog.pop_front());
          if (step_res.size() == 0) note(KIND_ACKED, 0, 0, 0);
        end
      end
      CMD_TICK: begin
        if (!timer_on) note(KIND_IDLE, 0, 0, 0);
        else if (ticks_left > 1) begin
          ticks_left--;
          note(KIND_IDLE, 0, 0, 0);
        end else if (outs == 0) begin
          timer_on   = 1'b0;
          ticks_left = '0;
          note(KIND_IDLE, 0, 0, 0);
        end else begin
          ticks_left = eff_timeout();
          for (int i = 0; i < outs && i < 8; i++)
            note(KIND_RESENT, win_base + i, sent_store[i], 1);
        end
      end
      default: note(KIND_IDLE, 0, 0, 0);
    endcase
    step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) awaited.push_back(step_res[i]);
  endfunction

  always @(posedge clk) begin
    pkt_result_t exp_r;
    pkt_result_t got;
    if (!rst_n) begin
      timeout_reg = 16'd20;
      window_reg  = 4'd8;
      buffer_reg  = 7'd50;
      win_base    = 1;
      next_seq    = 1;
      backlog.delete();
      awaited.delete();
      timer_on    = 1'b0;
      ticks_left  = '0;
      fails       = 0;
      n_items     = 0;
      n_results   = 0;
    end else begin
      // Results are checked before the new item is predicted, since the
      // block cannot answer an item in the cycle that accepts it.
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        got = '0;
        got.kind  = out_ch.kind;
        got.seq   = out_ch.out_seqnum;
        got.cksum = out_ch.out_checksum;
        got.pay   = {out_ch.out_payload_high, out_ch.out_payload_mid, out_ch.out_payload_low};
        got.last  = out_ch.last;
        if (awaited.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item: kind %0d seq %0d",
                                    got.kind, got.seq);
        end else begin
          exp_r = awaited.pop_front();
          if (got.kind !== exp_r.kind || got.seq !== exp_r.seq || out_ch.out_acknum !== 1'b0
              || got.cksum !== exp_r.cksum || got.pay !== exp_r.pay
              || got.last !== exp_r.last) begin
            fails++;
            if (fails <= 10) begin
              $display("result mismatch: expected kind %0d seq %0d ack 0 cksum %h last %0d",
                       exp_r.kind, exp_r.seq, exp_r.cksum, exp_r.last);
              $display("  got kind %0d seq %0d ack %0d cksum %h last %0d", got.kind,
                       got.seq, out_ch.out_acknum, got.cksum, got.last);
              $display("  payload expected %h got %h", exp_r.pay, got.pay);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_reg = cfg_wdata;
          CFG_WINDOW:  window_reg  = cfg_wdata[3:0];
          CFG_BUFFER:  buffer_reg  = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        n_items++;
        predict(in_ch.cmd, {in_ch.payload_high, in_ch.payload_mid, in_ch.payload_low},
                in_ch.in_seqnum, in_ch.in_acknum, in_ch.in_checksum);
      end
    end
  end
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the Go-Back-N sender testbench: clock, reset, command stimulus,
// register phases and the verdict. Depends on gbn_pkg, gbn_tb_pkg,
// the channel interfaces and gbn_checker.
module testbench;
  import gbn_pkg::*;
  import gbn_tb_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic calm;
  logic stall_req;
  int   fails, pending, n_items, n_results;
  int   cycles;
  logic [SEQ_W-1:0] base_now, next_now;

  gbn_in_if  in_ch ();
  gbn_out_if out_ch ();

  go_back_n_sender dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  gbn_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending), .n_items(n_items), .n_results(n_results),
    .base_o(base_now), .next_o(next_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 300000) begin
        $display("go_back_n_sender: mismatch");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    stall_req = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  function automatic logic [PAY_W-1:0] rand_payload();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic put_item(logic [1:0] cmd, logic [PAY_W-1:0] pay,
                          logic [31:0] sq, logic [31:0] ack, logic [31:0] ck);
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.payload_low  <= pay[63:0];
    in_ch.payload_mid  <= pay[127:64];
    in_ch.payload_high <= pay[159:128];
    in_ch.in_seqnum    <= sq;
    in_ch.in_acknum    <= ack;
    in_ch.in_checksum  <= ck;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // An acknowledgement with a correct checksum; the window position is
  // read after the valid is dropped, so that it reflects every earlier item.
  task automatic put_ack(logic [31:0] ack);
    logic [PAY_W-1:0] pay;
    logic [31:0] sq;
    pay = rand_payload();
    sq  = $urandom;
    put_item(CMD_ACK, pay, sq, ack, payload_byte_sum(pay) + sq + ack);
  endtask

  task automatic ack_at(int unsigned offset);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    put_ack({1'b0, base_now + offset[SEQ_W-1:0]});
  endtask

  task automatic put_random();
    int unsigned pick, sel;
    logic [SEQ_W-1:0] outs;
    logic [PAY_W-1:0] pay;
    logic [31:0] sq, ack;
    pick = $urandom_range(0, 99);
    pay  = rand_payload();
    outs = next_now - base_now;
    if (pick < 45) put_item(CMD_SEND, pay, $urandom, $urandom, $urandom);
    else if (pick < 75) begin
      sel = $urandom_range(0, 99);
      sq  = $urandom;
      if (sel < 75 && outs > 0)
        ack = {1'b0, SEQ_W'(base_now + $urandom_range(0, outs - 1))};
      else ack = $urandom;
      if (sel >= 75 && sel < 88) put_item(CMD_ACK, pay, sq, ack, $urandom);
      else put_item(CMD_ACK, pay, sq, ack, payload_byte_sum(pay) + sq + ack);
    end else if (pick < 96) put_item(CMD_TICK, pay, $urandom, $urandom, $urandom);
    else put_item(2'd3, pay, $urandom, $urandom, $urandom);
  endtask

  // Let every awaited result drain, then allow for the block's own latency.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(logic [CFG_W-1:0] tmo, logic [CFG_W-1:0] win,
                            logic [CFG_W-1:0] buf_lim);
    cfg_we <= 1'b1; cfg_index <= CFG_TIMEOUT; cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= CFG_WINDOW; cfg_wdata <= win;
    @(posedge clk);
    cfg_index <= CFG_BUFFER; cfg_wdata <= buf_lim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    calm <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_TICK;
    in_ch.payload_low <= '0;
    in_ch.payload_mid <= '0;
    in_ch.payload_high <= '0;
    in_ch.in_seqnum <= '0;
    in_ch.in_acknum <= '0;
    in_ch.in_checksum <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme payloads, every acknowledgement outcome, expiry.
    write_regs(16'd2, 16'd8, 16'd50);
    put_item(CMD_TICK, '0, 0, 0, 0);
    put_item(CMD_SEND, {PAY_W{1'b1}}, 0, 0, 0);
    put_item(CMD_SEND, {20{8'h80}}, 0, 0, 0);
    put_item(CMD_SEND, {20{8'h7F}}, 0, 0, 0);
    put_item(CMD_SEND, '0, 0, 0, 0);
    put_item(CMD_SEND, rand_payload(), 0, 0, 0);
    ack_at(1);
    put_item(CMD_ACK, rand_payload(), 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    put_ack(32'h8000_0001);
    ack_at(10);
    put_item(2'd3, {PAY_W{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_item(CMD_TICK, '0, 0, 0, 0);
    put_item(CMD_TICK, '0, 0, 0, 0);
    ack_at(2);
    put_item(CMD_TICK, '0, 0, 0, 0);
    settle();

    // Smallest window and queue: send, queue, drop, then drain on an ack.
    write_regs(16'd1, 16'd1, 16'd1);
    repeat (3) put_item(CMD_SEND, rand_payload(), 0, 0, 0);
    ack_at(0);
    put_item(CMD_TICK, '0, 0, 0, 0);
    put_item(CMD_TICK, '0, 0, 0, 0);
    settle();

    // Largest settings; the result side holds off while the queue fills.
    write_regs(16'hFFFF, 16'd15, 16'd127);
    stall_req = 1'b1;
    repeat (80) put_item(CMD_SEND, rand_payload(), 0, 0, 0);
    settle();
    repeat (10) ack_at($urandom_range(0, 7));
    repeat (40) put_random();
    settle();

    write_regs(16'd0, 16'd0, 16'd0);
    repeat (30) put_random();
    settle();

    write_regs(16'd3, 16'd4, 16'd5);
    repeat (30) put_random();
    calm <= 1'b1;
    repeat (40) put_random();
    calm <= 1'b0;
    repeat (30) put_random();
    settle();

    write_regs(16'd5, 16'd2, 16'd20);
    repeat (30) put_random();
    settle();

    $display("Ran %0d command items through six register settings, %0d result items checked.",
             n_items, n_results);
    if (fails == 0) begin
      $display("go_back_n_sender: match");
    end else begin
      $display("go_back_n_sender: mismatch");
    end
    $finish;
  end
endmodule

FILE: go_back_n_sender.f
hdl/gbn_pkg.sv
hdl/gbn_if.sv
hdl/go_back_n_sender.sv
verif/gbn_tb_pkg.sv
verif/gbn_checker.sv
verif/testbench.sv
